/* rtl/unique_list_sort_search_unit_macros.svh */
// Assertion macros shared by the unique list sort/search unit.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef UNIQUE_LIST_SORT_SEARCH_UNIT_MACROS_SVH
`define UNIQUE_LIST_SORT_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ULSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ULSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ulss_pkg.sv */
// Shared types and constants for the unique list sort/search unit.
// No dependencies.
package ulss_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KEY_W = 16;
    localparam int POS_W = 5;

    typedef enum logic [1:0] {
        FN_INSERT   = 2'd0,
        FN_SORT_ASC = 2'd1,
        FN_SORT_DSC = 2'd2,
        FN_SEARCH   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_DUP      = 3'd1,
        ST_FOUND    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_FULL_OK  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT_V,
        S_CMP,
        S_WR0,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [KEY_W-1:0] wdata;
        logic [AW-1:0]    raddr;
    } ram_req_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [POS_W-1:0] position;
    } result_t;

endpackage

/* rtl/ulss_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ulss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ulss_ctrl.sv */
// Sequencer for the unique list: scans for insert/search and runs the
// insertion sort over the table RAM. Depends on ulss_pkg and the macro header.
`include "unique_list_sort_search_unit_macros.svh"

module ulss_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic signed [15:0]      key,
    output ulss_pkg::ram_req_t      ram_req,
    input  logic [15:0]             ram_rdata,
    output ulss_pkg::result_t       res,
    input  logic                    out_free
);

    ulss_pkg::state_t state_reg, state_next;
    ulss_pkg::func_t  func_reg, func_next;
    logic signed [15:0] key_reg, key_next;
    logic signed [15:0] v_reg, v_next;
    logic [ulss_pkg::CW-1:0] count_reg, count_next;
    logic [ulss_pkg::CW-1:0] a_reg, a_next;
    logic [ulss_pkg::CW-1:0] i_reg, i_next;
    logic [ulss_pkg::CW-1:0] j_reg, j_next;
    logic [ulss_pkg::AW-1:0] pidx_reg, pidx_next;
    logic                    pend_reg, pend_next;
    ulss_pkg::status_t       rstat_reg, rstat_next;
    logic [ulss_pkg::POS_W-1:0] rpos_reg, rpos_next;

    logic signed [15:0] rd;
    logic [ulss_pkg::CW-1:0] i_inc;
    logic [ulss_pkg::CW-1:0] pos_wide;
    logic move;

    logic count_ok;
    logic wr_state;
    logic sort_idx_ok;
    logic res_wait;

    assign rd       = $signed(ram_rdata);
    assign i_inc    = i_reg + 1'b1;
    assign pos_wide = ulss_pkg::CW'(pidx_reg) + 1'b1;
    assign move     = (func_reg == ulss_pkg::FN_SORT_DSC) ? (rd < v_reg) : (rd > v_reg);

    assign in_stall     = (state_reg != ulss_pkg::S_IDLE);
    assign res.valid    = (state_reg == ulss_pkg::S_DONE);
    assign res.status   = rstat_reg;
    assign res.position = rpos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ulss_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        key_reg   <= key_next;
        v_reg     <= v_next;
        a_reg     <= a_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        pidx_reg  <= pidx_next;
        rstat_reg <= rstat_next;
        rpos_reg  <= rpos_next;
    end

    // Reads and writes never touch the same entry in one cycle: the sort writes
    // entry j while it reads j-2 or the next outer entry, so no forwarding is needed.
    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        v_next        = v_reg;
        count_next    = count_reg;
        a_next        = a_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pidx_next     = pidx_reg;
        pend_next     = 1'b0;
        rstat_next    = rstat_reg;
        rpos_next     = rpos_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = '0;
        ram_req.wdata = '0;
        ram_req.raddr = '0;

        case (state_reg)
            ulss_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = ulss_pkg::func_t'(func);
                    key_next  = key;
                    a_next    = '0;
                    rpos_next = '0;
                    if (ulss_pkg::func_t'(func) == ulss_pkg::FN_INSERT)
                    begin
                        state_next = ulss_pkg::S_SCAN;
                    end
                    else if (count_reg == '0)
                    begin
                        rstat_next = ulss_pkg::ST_EMPTY;
                        state_next = ulss_pkg::S_DONE;
                    end
                    else if (ulss_pkg::func_t'(func) == ulss_pkg::FN_SEARCH)
                    begin
                        state_next = ulss_pkg::S_SCAN;
                    end
                    else if (count_reg == ulss_pkg::CW'(1))
                    begin
                        rstat_next = ulss_pkg::ST_FULL_OK;
                        state_next = ulss_pkg::S_DONE;
                    end
                    else
                    begin
                        ram_req.raddr = ulss_pkg::AW'(1);
                        i_next        = ulss_pkg::CW'(1);
                        j_next        = ulss_pkg::CW'(1);
                        state_next    = ulss_pkg::S_WAIT_V;
                    end
                end
            end

            ulss_pkg::S_SCAN:
            begin
                if (a_reg < count_reg)
                begin
                    ram_req.raddr = a_reg[ulss_pkg::AW-1:0];
                    pidx_next     = a_reg[ulss_pkg::AW-1:0];
                    pend_next     = 1'b1;
                    a_next        = a_reg + 1'b1;
                end
                if (pend_reg && (rd == key_reg))
                begin
                    if (func_reg == ulss_pkg::FN_INSERT)
                    begin
                        rstat_next = ulss_pkg::ST_DUP;
                    end
                    else
                    begin
                        rstat_next = ulss_pkg::ST_FOUND;
                        rpos_next  = pos_wide[ulss_pkg::POS_W-1:0];
                    end
                    pend_next  = 1'b0;
                    state_next = ulss_pkg::S_DONE;
                end
                else if (!pend_reg && (a_reg == count_reg))
                begin
                    if (func_reg != ulss_pkg::FN_INSERT)
                    begin
                        rstat_next = ulss_pkg::ST_NOTFOUND;
                    end
                    else if (count_reg >= ulss_pkg::CW'(ulss_pkg::DEPTH))
                    begin
                        rstat_next = ulss_pkg::ST_FULL_OK;
                    end
                    else
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = count_reg[ulss_pkg::AW-1:0];
                        ram_req.wdata = key_reg;
                        count_next    = count_reg + 1'b1;
                        rstat_next    = ulss_pkg::ST_ADDED;
                    end
                    state_next = ulss_pkg::S_DONE;
                end
            end

            ulss_pkg::S_WAIT_V:
            begin
                v_next        = rd;
                ram_req.raddr = ulss_pkg::AW'(j_reg - 1'b1);
                state_next    = ulss_pkg::S_CMP;
            end

            ulss_pkg::S_CMP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg[ulss_pkg::AW-1:0];
                if (move)
                begin
                    ram_req.wdata = rd;
                    j_next        = j_reg - 1'b1;
                    if (j_reg == ulss_pkg::CW'(1))
                    begin
                        state_next = ulss_pkg::S_WR0;
                    end
                    else
                    begin
                        ram_req.raddr = ulss_pkg::AW'(j_reg - ulss_pkg::CW'(2));
                    end
                end
                else
                begin
                    ram_req.wdata = v_reg;
                    if (i_inc < count_reg)
                    begin
                        ram_req.raddr = i_inc[ulss_pkg::AW-1:0];
                        i_next        = i_inc;
                        j_next        = i_inc;
                        state_next    = ulss_pkg::S_WAIT_V;
                    end
                    else
                    begin
                        rstat_next = ulss_pkg::ST_FULL_OK;
                        state_next = ulss_pkg::S_DONE;
                    end
                end
            end

            ulss_pkg::S_WR0:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = v_reg;
                if (i_inc < count_reg)
                begin
                    ram_req.raddr = i_inc[ulss_pkg::AW-1:0];
                    i_next        = i_inc;
                    j_next        = i_inc;
                    state_next    = ulss_pkg::S_WAIT_V;
                end
                else
                begin
                    rstat_next = ulss_pkg::ST_FULL_OK;
                    state_next = ulss_pkg::S_DONE;
                end
            end

            ulss_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = ulss_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ulss_pkg::S_IDLE;
            end
        endcase
    end

    assign count_ok    = (count_reg <= ulss_pkg::CW'(ulss_pkg::DEPTH));
    assign wr_state    = (state_reg == ulss_pkg::S_SCAN) || (state_reg == ulss_pkg::S_CMP)
                         || (state_reg == ulss_pkg::S_WR0);
    assign sort_idx_ok = (j_reg != '0) && (j_reg <= i_reg) && (i_reg < count_reg);
    assign res_wait    = res.valid && !out_free;

    `ULSS_ASSERT_NOW(a_count_bound, 1'b1, count_ok, "count above depth")
    `ULSS_ASSERT_NOW(a_write_states, ram_req.we, wr_state, "RAM write outside scan or sort")
    `ULSS_ASSERT_NOW(a_sort_index, state_reg == ulss_pkg::S_CMP, sort_idx_ok, "bad sort index")
    `ULSS_ASSERT_NEXT(a_result_hold, res_wait, $stable(res), "pending result changed")

endmodule

/* rtl/unique_list_sort_search_unit.sv */
// Unique list sort/search unit: an ordered table of distinct signed keys.
// Channels: input (in_valid, in_stall, func, key) and output (out_valid,
// out_stall, status, position); an item moves when valid is high and stall low.
// Every input item yields exactly one result item, in order.
// Insert and search scan the table through the RAM read port, one entry per
// cycle; an early match ends the scan. A sort takes each entry in turn, moves
// the entries before it that belong after it up by one, and writes it into
// the freed slot, bounded by the single read and single write port of the RAM.
// Items are handled one at a time; in_stall is high while an item is in work.
// The result register lets the next item start while a result waits; the
// sequencer holds its finished result only while that register is still full.
// Reset clears the entry count and the control state. The table needs no
// clearing pass: only entries below the count are ever read.
// While out_valid and out_stall are both high the result register holds status and position.
// Depends on ulss_pkg, ulss_ram and ulss_ctrl.
module unique_list_sort_search_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [15:0] key,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [4:0]         position
);

    ulss_pkg::ram_req_t ram_req;
    ulss_pkg::result_t  res;
    logic [15:0]        ram_rdata;
    logic               out_free;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         status_reg;
    logic [4:0]         position_reg;

    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid_next = res.valid ? 1'b1 : (out_valid_reg && out_stall);

    ulss_ram #(
        .WIDTH (ulss_pkg::KEY_W),
        .DEPTH (ulss_pkg::DEPTH),
        .AW    (ulss_pkg::AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    ulss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .key       (key),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res       (res),
        .out_free  (out_free)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && out_free)
        begin
            status_reg   <= res.status;
            position_reg <= res.position;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;

endmodule

/* verif/tb_unique_list_sort_search_unit.sv */
// Testbench for unique_list_sort_search_unit: directed and random table operations,
// each result checked against a behavioral model of the key table kept here.
// Depends on ulss_pkg and the unique_list_sort_search_unit RTL.
`timescale 1ns / 100ps

module tb_unique_list_sort_search_unit;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int DEPTH = ulss_pkg::DEPTH;
    localparam int POS_W = ulss_pkg::POS_W;

    typedef struct {
        ulss_pkg::status_t status;
        logic [POS_W-1:0]  position;
    } outcome_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         func;
    logic signed [15:0] key;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [4:0]         position;

    // Model of the key table, updated as each item is accepted.
    logic signed [15:0] tbl [DEPTH];
    int                 tbl_count;
    outcome_t           pending_q [$];

    int errors = 0;
    int items_sent;
    int hits [6] = '{default: 0};
    int idle_cycles = 0;
    bit no_gaps;
    bit hold_request;

    unique_list_sort_search_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .position  (position)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic int find_key(logic signed [15:0] k);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic logic signed [15:0] fresh_key();
        logic signed [15:0] k;
        do
            k = 16'($urandom);
        while (find_key(k) >= 0);
        return k;
    endfunction

    function automatic void table_sort(bit descending);
        logic signed [15:0] v;
        int                 j;
        for (int i = 1; i < tbl_count; i++)
        begin
            v = tbl[i];
            j = i;
            while (j > 0 && (descending ? (tbl[j-1] < v) : (tbl[j-1] > v)))
            begin
                tbl[j] = tbl[j-1];
                j--;
            end
            tbl[j] = v;
        end
    endfunction

    function automatic void table_predict(input ulss_pkg::func_t op,
                                          input logic signed [15:0] k,
                                          output outcome_t res);
        int idx;
        idx = find_key(k);
        res.status   = ulss_pkg::ST_EMPTY;
        res.position = '0;
        case (op)
            ulss_pkg::FN_INSERT:
            begin
                // The duplicate check wins over the full check.
                if (idx >= 0)
                    res.status = ulss_pkg::ST_DUP;
                else if (tbl_count >= DEPTH)
                    res.status = ulss_pkg::ST_FULL_OK;
                else
                begin
                    tbl[tbl_count] = k;
                    tbl_count++;
                    res.status = ulss_pkg::ST_ADDED;
                end
            end
            ulss_pkg::FN_SEARCH:
            begin
                if (tbl_count == 0)
                    res.status = ulss_pkg::ST_EMPTY;
                else if (idx >= 0)
                begin
                    res.status   = ulss_pkg::ST_FOUND;
                    res.position = POS_W'(idx + 1);
                end
                else
                    res.status = ulss_pkg::ST_NOTFOUND;
            end
            default:
            begin
                if (tbl_count == 0)
                    res.status = ulss_pkg::ST_EMPTY;
                else
                begin
                    table_sort(op == ulss_pkg::FN_SORT_DSC);
                    res.status = ulss_pkg::ST_FULL_OK;
                end
            end
        endcase
    endfunction

    // Offers one item, holding it until accepted, then records its expected result.
    task automatic send_item(ulss_pkg::func_t op, logic signed [15:0] k);
        int       gap;
        outcome_t want;
        @(negedge clk);
        if (!no_gaps && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        table_predict(op, k, want);
        pending_q.push_back(want);
        items_sent++;
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_op();
        int                 pick;
        logic signed [15:0] k;
        pick = $urandom_range(0, 99);
        k    = 16'($urandom);
        if (pick < 30 && tbl_count > 0)
            send_item(ulss_pkg::FN_SEARCH, tbl[$urandom_range(0, tbl_count - 1)]);
        else if (pick < 45)
            send_item(ulss_pkg::FN_SEARCH, k);
        else if (pick < 60)
            send_item(ulss_pkg::FN_SORT_ASC, k);
        else if (pick < 75)
            send_item(ulss_pkg::FN_SORT_DSC, k);
        else if (pick < 85 && tbl_count > 0)
            send_item(ulss_pkg::FN_INSERT, tbl[$urandom_range(0, tbl_count - 1)]);
        else
            send_item(ulss_pkg::FN_INSERT, k);
    endtask

    task automatic test_empty_table();
        send_item(ulss_pkg::FN_SEARCH, 16'sd5);
        send_item(ulss_pkg::FN_SORT_ASC, 16'sd0);
        send_item(ulss_pkg::FN_SORT_DSC, -16'sd1);
        send_item(ulss_pkg::FN_INSERT, 16'sh8000);
        // A single entry sorts to itself.
        send_item(ulss_pkg::FN_SORT_ASC, 16'sd0);
        send_item(ulss_pkg::FN_SORT_DSC, 16'sd0);
        send_item(ulss_pkg::FN_SEARCH, 16'sh8000);
        wait_results();
    endtask

    task automatic test_insert_extremes();
        send_item(ulss_pkg::FN_INSERT, 16'sh7fff);
        send_item(ulss_pkg::FN_INSERT, 16'sd0);
        send_item(ulss_pkg::FN_INSERT, -16'sd1);
        send_item(ulss_pkg::FN_INSERT, 16'sd1);
        send_item(ulss_pkg::FN_INSERT, 16'sh7fff);
        send_item(ulss_pkg::FN_INSERT, 16'sh8000);
        wait_results();
    endtask

    task automatic test_search_and_sort();
        send_item(ulss_pkg::FN_SEARCH, 16'sd0);
        send_item(ulss_pkg::FN_SEARCH, 16'sd2);
        send_item(ulss_pkg::FN_SORT_ASC, 16'sh7fff);
        send_item(ulss_pkg::FN_SEARCH, 16'sh7fff);
        send_item(ulss_pkg::FN_SORT_DSC, 16'sh8000);
        send_item(ulss_pkg::FN_SEARCH, 16'sh7fff);
        send_item(ulss_pkg::FN_SEARCH, 16'sh8000);
        wait_results();
    endtask

    task automatic test_fill_table();
        int pick;
        while (tbl_count < DEPTH)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_item(ulss_pkg::FN_INSERT, fresh_key());
            else if (pick < 75)
                send_item(ulss_pkg::FN_INSERT, tbl[$urandom_range(0, tbl_count - 1)]);
            else if (pick < 88)
                send_item(ulss_pkg::FN_SEARCH, tbl[$urandom_range(0, tbl_count - 1)]);
            else if (pick < 94)
                send_item(ulss_pkg::FN_SORT_ASC, 16'($urandom));
            else
                send_item(ulss_pkg::FN_SORT_DSC, 16'($urandom));
        end
        wait_results();
    endtask

    task automatic test_full_table();
        send_item(ulss_pkg::FN_INSERT, fresh_key());
        send_item(ulss_pkg::FN_INSERT, tbl[0]);
        send_item(ulss_pkg::FN_SORT_ASC, 16'sd0);
        send_item(ulss_pkg::FN_SEARCH, tbl[DEPTH-1]);
        send_item(ulss_pkg::FN_SORT_DSC, 16'sd0);
        send_item(ulss_pkg::FN_SEARCH, tbl[0]);
        wait_results();
    endtask

    task automatic test_random_mix(int n);
        repeat (n) random_op();
        wait_results();
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_stall_pressure();
        hold_request = 1'b1;
        repeat (40) random_op();
        wait_results();
    endtask

    task automatic test_no_gap_burst();
        no_gaps = 1'b1;
        repeat (80) random_op();
        wait_results();
        no_gaps = 1'b0;
    endtask

    // Receiver: random stalls, or one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= !no_gaps && ($urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk)
    begin : check_result
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: status %0d position %0d", status, position);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    errors++;
                end
                if (position !== want.position)
                begin
                    $error("position: expected %0d, actual %0d", want.position, position);
                    errors++;
                end
                hits[int'(want.status)]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("unique_list_sort_search_unit test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = ulss_pkg::FN_INSERT;
        key          = '0;
        tbl_count    = 0;
        items_sent   = 0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_insert_extremes();
        test_search_and_sort();
        test_fill_table();
        test_full_table();
        test_random_mix(1150);
        test_stall_pressure();
        test_no_gap_burst();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d items: %0d added, %0d duplicate, %0d found, %0d not found,",
                 items_sent, hits[ulss_pkg::ST_ADDED], hits[ulss_pkg::ST_DUP],
                 hits[ulss_pkg::ST_FOUND], hits[ulss_pkg::ST_NOTFOUND]);
        $display("%0d on an empty table, %0d full or sorted; %0d mismatches.",
                 hits[ulss_pkg::ST_EMPTY], hits[ulss_pkg::ST_FULL_OK], errors);
        if (errors == 0)
            $display("unique_list_sort_search_unit test passed");
        else
            $display("unique_list_sort_search_unit test failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ulss_pkg.sv
rtl/ulss_ram.sv
rtl/ulss_ctrl.sv
rtl/unique_list_sort_search_unit.sv
verif/tb_unique_list_sort_search_unit.sv
